// ----- hw/rtl/generational_handle_allocator_macros.svh -----
// ----------------------------------------------------------------------------
// Generational handle allocator assertion macros
// Shared property wrappers for the allocator checker.
// ----------------------------------------------------------------------------
`ifndef GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH
`define GENERATIONAL_HANDLE_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define GHA_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define GHA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/gha_pkg.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator package
// Default sizes, command and status codes, controller states.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gha_pkg;

  localparam int unsigned GHA_SLOTS    = 1024;
  localparam int unsigned GHA_GEN_BITS = 16;

  typedef enum logic [1:0] {
    CMD_CREATE  = 2'd0,
    CMD_DESTROY = 2'd1,
    CMD_QUERY   = 2'd2,
    CMD_NONE    = 2'd3
  } gha_cmd_e;

  typedef enum logic [1:0] {
    STAT_OK       = 2'd0,
    STAT_FULL     = 2'd1,
    STAT_NOT_LIVE = 2'd2
  } gha_status_e;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_EXEC  = 3'b010,
    ST_REUSE = 3'b100
  } gha_state_e;

endpackage

`default_nettype wire

// ----- hw/rtl/gha_ram.sv -----
// ----------------------------------------------------------------------------
// Allocator RAM
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gha_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/generational_handle_allocator.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator
// Hands out (index, generation) handles, reuses freed slots LIFO, checks
// handles on destroy and query.
//
//  channel  dir  handshake               payload
//  s_axis   in   s_axis_tvalid/tready    tuser: cmd; tdata: slot_index, slot_generation
//  m_axis   out  m_axis_tvalid/tready    tuser: status; tdata: is_live, handle_index,
//                                        handle_generation
//
// One item in flight: each item goes ST_IDLE, ST_EXEC; a create that reuses a freed
// slot also passes ST_REUSE (free stack read, then slot RAM read).
// Reset clears counters and control only; RAM contents are never cleared.
// The result register lets the next item enter while a result is stalled.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module generational_handle_allocator
  import gha_pkg::*;
#(
  parameter int unsigned SLOTS    = GHA_SLOTS,
  parameter int unsigned GEN_BITS = GHA_GEN_BITS,
  localparam int unsigned IDX_W   = $clog2(SLOTS),
  localparam int unsigned IN_W    = ((IDX_W + GEN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W   = ((1 + IDX_W + GEN_BITS + 7) / 8) * 8
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             s_axis_tvalid,
  output logic                  s_axis_tready,
  // slot_index, slot_generation
  input  wire logic [IN_W-1:0]  s_axis_tdata,
  // cmd
  input  wire logic [1:0]       s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  wire logic             m_axis_tready,
  // is_live, handle_index, handle_generation
  output logic [OUT_W-1:0]      m_axis_tdata,
  // status
  output logic [1:0]            m_axis_tuser
);

  localparam int unsigned CNT_W = $clog2(SLOTS + 1);
  localparam int unsigned ENT_W = GEN_BITS + 1;

  gha_state_e           state_q, state_d;
  gha_cmd_e             cmd_q;
  logic [IDX_W-1:0]     idx_q;
  logic [GEN_BITS-1:0]  gen_q;
  logic [IDX_W-1:0]     slot_q, slot_d;
  logic [CNT_W-1:0]     fc_q, fc_d;
  logic [CNT_W-1:0]     hw_q, hw_d;

  logic                 m_valid_q, m_valid_d;
  gha_status_e          m_status_q;
  logic                 m_live_q;
  logic [IDX_W-1:0]     m_idx_q;
  logic [GEN_BITS-1:0]  m_gen_q;

  logic                 accept;
  logic                 out_free;
  logic                 load;
  gha_status_e          res_status;
  logic                 res_live;
  logic [IDX_W-1:0]     res_idx;
  logic [GEN_BITS-1:0]  res_gen;

  logic                 slot_we, slot_re;
  logic [IDX_W-1:0]     slot_waddr, slot_raddr;
  logic [ENT_W-1:0]     slot_wdata, slot_rdata;
  logic                 fs_we;
  logic [IDX_W-1:0]     fs_waddr, fs_raddr;
  logic [IDX_W-1:0]     fs_wdata, fs_rdata;
  logic                 live_hit;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;

  assign fs_raddr = IDX_W'(fc_q - CNT_W'(1));
  assign live_hit = (CNT_W'(idx_q) < hw_q) && slot_rdata[GEN_BITS] &&
                    (slot_rdata[GEN_BITS-1:0] == gen_q);

  gha_ram #(.WIDTH(ENT_W), .DEPTH(SLOTS)) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (slot_we),
    .waddr_i (slot_waddr),
    .wdata_i (slot_wdata),
    .re_i    (slot_re),
    .raddr_i (slot_raddr),
    .rdata_o (slot_rdata)
  );

  gha_ram #(.WIDTH(IDX_W), .DEPTH(SLOTS)) u_free_ram (
    .clk_i   (clk_i),
    .we_i    (fs_we),
    .waddr_i (fs_waddr),
    .wdata_i (fs_wdata),
    .re_i    (accept),
    .raddr_i (fs_raddr),
    .rdata_o (fs_rdata)
  );

  always_comb begin
    state_d    = state_q;
    slot_d     = slot_q;
    fc_d       = fc_q;
    hw_d       = hw_q;
    load       = 1'b0;
    res_status = STAT_OK;
    res_live   = 1'b0;
    res_idx    = '0;
    res_gen    = '0;
    slot_we    = 1'b0;
    slot_waddr = idx_q;
    slot_wdata = '0;
    slot_re    = accept;
    slot_raddr = s_axis_tdata[IDX_W-1:0];
    fs_we      = 1'b0;
    fs_waddr   = fc_q[IDX_W-1:0];
    fs_wdata   = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (cmd_q)
          CMD_CREATE: begin
            if (fc_q != '0) begin
              slot_re    = 1'b1;
              slot_raddr = fs_rdata;
              slot_d     = fs_rdata;
              fc_d       = fc_q - CNT_W'(1);
              state_d    = ST_REUSE;
            end else if (out_free) begin
              load    = 1'b1;
              state_d = ST_IDLE;
              if (hw_q < CNT_W'(SLOTS)) begin
                slot_we    = 1'b1;
                slot_waddr = IDX_W'(hw_q);
                slot_wdata = {1'b1, {GEN_BITS{1'b0}}};
                hw_d       = hw_q + CNT_W'(1);
                res_live   = 1'b1;
                res_idx    = IDX_W'(hw_q);
              end else begin
                res_status = STAT_FULL;
              end
            end
          end
          CMD_DESTROY: begin
            if (out_free) begin
              load    = 1'b1;
              state_d = ST_IDLE;
              if (live_hit && (fc_q < CNT_W'(SLOTS))) begin
                slot_we    = 1'b1;
                slot_wdata = {1'b0, slot_rdata[GEN_BITS-1:0] + GEN_BITS'(1)};
                fs_we      = 1'b1;
                fc_d       = fc_q + CNT_W'(1);
              end else begin
                res_status = STAT_NOT_LIVE;
              end
            end
          end
          CMD_QUERY: begin
            if (out_free) begin
              load     = 1'b1;
              state_d  = ST_IDLE;
              res_live = live_hit;
            end
          end
          default: begin
            if (out_free) begin
              load    = 1'b1;
              state_d = ST_IDLE;
            end
          end
        endcase
      end
      ST_REUSE: begin
        if (out_free) begin
          load       = 1'b1;
          state_d    = ST_IDLE;
          slot_we    = 1'b1;
          slot_waddr = slot_q;
          slot_wdata = {1'b1, slot_rdata[GEN_BITS-1:0]};
          res_live   = 1'b1;
          res_idx    = slot_q;
          res_gen    = slot_rdata[GEN_BITS-1:0];
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    m_valid_d = m_valid_q;
    if (load) begin
      m_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      m_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      fc_q      <= '0;
      hw_q      <= '0;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      fc_q      <= fc_d;
      hw_q      <= hw_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
    if (accept) begin
      cmd_q <= gha_cmd_e'(s_axis_tuser);
      idx_q <= s_axis_tdata[IDX_W-1:0];
      gen_q <= s_axis_tdata[IDX_W +: GEN_BITS];
    end
    if (load) begin
      m_status_q <= res_status;
      m_live_q   <= res_live;
      m_idx_q    <= res_idx;
      m_gen_q    <= res_gen;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tuser  = m_status_q;
  assign m_axis_tdata  = OUT_W'({m_gen_q, m_idx_q, m_live_q});

endmodule

`default_nettype wire

// ----- hw/rtl/gha_checker.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator checker
// Port-level properties of the allocator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "generational_handle_allocator_macros.svh"

module gha_checker
  import gha_pkg::*;
#(
  parameter int unsigned SLOTS    = GHA_SLOTS,
  parameter int unsigned GEN_BITS = GHA_GEN_BITS,
  localparam int unsigned IDX_W   = $clog2(SLOTS),
  localparam int unsigned IN_W    = ((IDX_W + GEN_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W   = ((1 + IDX_W + GEN_BITS + 7) / 8) * 8
) (
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             s_axis_tvalid,
  input wire logic             s_axis_tready,
  // slot_index, slot_generation
  input wire logic [IN_W-1:0]  s_axis_tdata,
  // cmd
  input wire logic [1:0]       s_axis_tuser,
  input wire logic             m_axis_tvalid,
  input wire logic             m_axis_tready,
  // is_live, handle_index, handle_generation
  input wire logic [OUT_W-1:0] m_axis_tdata,
  // status
  input wire logic [1:0]       m_axis_tuser
);

  `GHA_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "result changed while stalled")

  `GHA_ASSERT_IMPL(a_err_clean, m_axis_tvalid && (m_axis_tuser != STAT_OK), m_axis_tdata == '0, "error result carries handle data")

  `GHA_ASSERT_IMPL(a_idx_live, m_axis_tvalid && (m_axis_tdata[IDX_W:1] != '0), m_axis_tdata[0], "handle index without live flag")

  `GHA_ASSERT_NEXT(a_one_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")

endmodule

bind generational_handle_allocator gha_checker #(
  .SLOTS    (SLOTS),
  .GEN_BITS (GEN_BITS)
) u_gha_checker (.*);

`default_nettype wire

// ----- dv/tb.sv -----
// ----------------------------------------------------------------------------
// Generational handle allocator testbench
// Sends create, destroy, query and no-op commands through the slave stream.
// A local allocator model predicts each result. Every returned result is
// compared field by field in order. Coverage spans LIFO slot reuse, stale
// and forged handles, repeated reuse of one slot across generations, a fill
// to the full state with a long output stall, and randomized traffic with
// bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import gha_pkg::*;

  localparam int unsigned SLOTS        = GHA_SLOTS;
  localparam int unsigned IN_W         = 32;
  localparam int unsigned OUT_W        = 32;
  localparam int          CYCLE_LIMIT  = 2_000_000;
  localparam int          HOLD_CYCLES  = 300;
  localparam int          DRAIN_WAIT   = 16;
  localparam int          PRINT_CAP    = 20;
  localparam int          REUSE_ROUNDS = 8;

  typedef struct packed {
    gha_status_e status;
    logic        is_live;
    logic [9:0]  index;
    logic [15:0] gen;
  } handle_result_t;

  logic             clk_i         = 1'b0;
  logic             rst_ni        = 1'b0;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  // slot_index [9:0], slot_generation [25:10], zero fill
  logic [IN_W-1:0]  s_axis_tdata  = '0;
  // cmd
  logic [1:0]       s_axis_tuser  = 2'd0;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  // is_live [0], handle_index [10:1], handle_generation [26:11], zero fill
  logic [OUT_W-1:0] m_axis_tdata;
  // status
  logic [1:0]       m_axis_tuser;

  generational_handle_allocator uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always #5 clk_i = ~clk_i;

  // allocator model state
  logic [15:0] gen_tab [SLOTS];
  logic        live_tab[SLOTS];
  logic [9:0]  free_stk[SLOTS];
  int          free_cnt   = 0;
  int          high_water = 0;
  logic [9:0]  live_slots[$];

  handle_result_t pending_results[$];

  int n_items = 0, n_checked = 0, n_errors = 0, n_cycles = 0;
  int n_creates = 0, n_full = 0, n_destroys = 0, n_rejects = 0;
  int n_queries = 0, n_live_hits = 0, n_noops = 0, n_wraps = 0;

  bit full_rate   = 1'b0;
  int burst_left  = 0;
  int hold_asked  = 0;
  int hold_done   = 0;
  int hold_left   = 0;
  logic [3:0]  rx_phase   = '0;
  logic [1:0]  rx_mode    = '0;
  logic [15:0] rx_pattern = '0;

  initial begin
    for (int k = 0; k < SLOTS; k++) begin
      gen_tab[k]  = '0;
      live_tab[k] = 1'b0;
      free_stk[k] = '0;
    end
  end

  function automatic bit handle_is_live(logic [9:0] idx, logic [15:0] gen);
    return (int'(idx) < high_water) && live_tab[idx] && (gen_tab[idx] == gen);
  endfunction

  function automatic handle_result_t allocator_predict(gha_cmd_e cmd, logic [9:0] idx,
                                                       logic [15:0] gen);
    handle_result_t r;
    logic [9:0]     slot;
    bit             got;
    r        = '0;
    r.status = STAT_OK;
    slot     = '0;
    got      = 1'b0;
    case (cmd)
      CMD_CREATE: begin
        n_creates++;
        if (free_cnt > 0) begin
          free_cnt--;
          slot = free_stk[free_cnt];
          got  = 1'b1;
        end else if (high_water < SLOTS) begin
          slot = high_water[9:0];
          high_water++;
          gen_tab[slot] = '0;
          got = 1'b1;
        end
        if (got) begin
          live_tab[slot] = 1'b1;
          r.is_live      = 1'b1;
          r.index        = slot;
          r.gen          = gen_tab[slot];
          live_slots.insert(live_slots.size(), slot);
        end else begin
          r.status = STAT_FULL;
          n_full++;
        end
      end
      CMD_DESTROY: begin
        n_destroys++;
        if (handle_is_live(idx, gen) && free_cnt < SLOTS) begin
          live_tab[idx] = 1'b0;
          if (gen_tab[idx] == '1) n_wraps++;
          gen_tab[idx] = gen_tab[idx] + 16'd1;
          free_stk[free_cnt] = idx;
          free_cnt++;
          for (int k = 0; k < live_slots.size(); k++) begin
            if (live_slots[k] == idx) begin
              live_slots.delete(k);
              break;
            end
          end
        end else begin
          r.status = STAT_NOT_LIVE;
          n_rejects++;
        end
      end
      CMD_QUERY: begin
        n_queries++;
        r.is_live = handle_is_live(idx, gen);
        if (r.is_live) n_live_hits++;
      end
      default: n_noops++;
    endcase
    return r;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    n_errors++;
    if (n_errors <= PRINT_CAP)
      $display("mismatch %s at result %0d: got %0d, want %0d", what, n_checked, got, want);
  endtask

  task automatic send_item(gha_cmd_e cmd, logic [9:0] idx, logic [15:0] gen);
    int gap;
    if (!full_rate) begin
      if (burst_left == 0) begin
        gap = $urandom_range(1, 8);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
        burst_left = $urandom_range(1, 32);
      end
      burst_left--;
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, gen, idx};
    s_axis_tuser  <= cmd;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    n_items++;
    pending_results.insert(pending_results.size(), allocator_predict(cmd, idx, gen));
  endtask

  always @(posedge clk_i) begin : result_check
    handle_result_t got, want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got.status  = gha_status_e'(m_axis_tuser);
      got.is_live = m_axis_tdata[0];
      got.index   = m_axis_tdata[10:1];
      got.gen     = m_axis_tdata[26:11];
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", int'(m_axis_tuser), -1);
      end else begin
        want = pending_results.pop_front();
        if (got.status != want.status)
          report_mismatch("status", int'(got.status), int'(want.status));
        if (got.is_live != want.is_live)
          report_mismatch("is_live", int'(got.is_live), int'(want.is_live));
        if (got.index != want.index)
          report_mismatch("handle_index", int'(got.index), int'(want.index));
        if (got.gen != want.gen)
          report_mismatch("handle_generation", int'(got.gen), int'(want.gen));
        n_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left     <= hold_left - 1;
    end else if (hold_asked != hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left     <= HOLD_CYCLES;
      hold_done     <= hold_done + 1;
    end else if (full_rate) begin
      m_axis_tready <= 1'b1;
    end else begin
      if (rx_phase == 4'd0) begin
        rx_mode    <= 2'($urandom_range(0, 3));
        rx_pattern <= 16'($urandom);
      end
      rx_phase <= rx_phase + 4'd1;
      case (rx_mode)
        2'd0:    m_axis_tready <= 1'b1;
        2'd1:    m_axis_tready <= rx_pattern[rx_phase];
        2'd2:    m_axis_tready <= rx_pattern[rx_phase] & rx_pattern[rx_phase + 4'd1];
        default: m_axis_tready <= ($urandom_range(0, 3) != 0);
      endcase
    end
  end

  always @(posedge clk_i) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("run timed out after %0d cycles, %0d results outstanding", n_cycles,
               pending_results.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_item(CMD_QUERY, 10'd0, 16'd0);
    send_item(CMD_DESTROY, 10'd0, 16'd0);
    send_item(CMD_CREATE, 10'd0, 16'd0);
    send_item(CMD_QUERY, 10'd0, 16'd0);
    send_item(CMD_QUERY, 10'd0, 16'd1);
    send_item(CMD_QUERY, 10'd1023, 16'hFFFF);
    send_item(CMD_DESTROY, 10'd0, 16'd1);
    send_item(CMD_DESTROY, 10'd0, 16'd0);
    send_item(CMD_DESTROY, 10'd0, 16'd0);
    send_item(CMD_QUERY, 10'd0, 16'd0);
    send_item(CMD_CREATE, 10'd1023, 16'hFFFF);
    send_item(CMD_CREATE, 10'd0, 16'd0);
    send_item(CMD_CREATE, 10'd0, 16'd0);
    send_item(CMD_DESTROY, 10'd1, 16'd0);
    send_item(CMD_DESTROY, 10'd2, 16'd0);
    send_item(CMD_CREATE, 10'd0, 16'd0);
    send_item(CMD_CREATE, 10'd0, 16'd0);
    send_item(CMD_NONE, 10'd1023, 16'hFFFF);
    send_item(CMD_NONE, 10'd0, 16'd0);
    send_item(CMD_QUERY, 10'd1, 16'd1);
    send_item(CMD_QUERY, 10'd2, 16'd1);
    send_item(CMD_DESTROY, 10'd1023, 16'hFFFF);
    send_item(CMD_QUERY, 10'd2, 16'd0);
  endtask

  // recycle slot 0 through several generations back to back
  task automatic test_generation_advance();
    full_rate = 1'b1;
    for (int n = 0; n < REUSE_ROUNDS; n++) begin
      send_item(CMD_DESTROY, 10'd0, gen_tab[0]);
      send_item(CMD_CREATE, 10'd0, 16'd0);
    end
    send_item(CMD_QUERY, 10'd0, gen_tab[0]);
    send_item(CMD_QUERY, 10'd0, gen_tab[0] - 16'd1);
    full_rate = 1'b0;
  endtask

  task automatic test_fill_to_full();
    hold_asked++;
    while (!(free_cnt == 0 && high_water == SLOTS))
      send_item(CMD_CREATE, 10'($urandom_range(0, 1023)), 16'($urandom));
    repeat (3) send_item(CMD_CREATE, 10'd0, 16'd0);
    send_item(CMD_QUERY, 10'd1023, gen_tab[1023]);
    send_item(CMD_DESTROY, 10'd1023, gen_tab[1023]);
    send_item(CMD_CREATE, 10'd0, 16'd0);
    send_item(CMD_CREATE, 10'd0, 16'd0);
    send_item(CMD_QUERY, 10'd1023, gen_tab[1023]);
  endtask

  task automatic test_random_traffic(int count);
    int          create_pct, r, k;
    logic [9:0]  idx;
    logic [15:0] gen;
    create_pct = 10;
    for (int i = 0; i < count; i++) begin
      if (i >= 300 && i % 150 == 0) create_pct = $urandom_range(10, 70);
      if (i == 400) hold_asked++;
      r = $urandom_range(0, 99);
      if (r < create_pct) begin
        send_item(CMD_CREATE, 10'($urandom_range(0, 1023)), 16'($urandom));
      end else if (r < create_pct + (100 - create_pct) / 2 && live_slots.size() > 0) begin
        idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
        send_item(CMD_DESTROY, idx, gen_tab[idx]);
      end else begin
        k = $urandom_range(0, 9);
        if ((k <= 2 || k == 9) && live_slots.size() > 0) begin
          idx = live_slots[$urandom_range(0, live_slots.size() - 1)];
          send_item(CMD_QUERY, idx, gen_tab[idx]);
        end else if (k <= 4 && high_water > 0) begin
          // any slot below the high-water mark with its current generation, or with a stale one
          idx = 10'($urandom_range(0, high_water - 1));
          gen = (k == 3) ? gen_tab[idx] : gen_tab[idx] - 16'($urandom_range(1, 65535));
          send_item(gha_cmd_e'($urandom_range(1, 2)), idx, gen);
        end else if (k == 8) begin
          send_item(CMD_NONE, 10'($urandom_range(0, 1023)), 16'($urandom));
        end else begin
          send_item(gha_cmd_e'($urandom_range(1, 2)), 10'($urandom_range(0, 1023)),
                    16'($urandom));
        end
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_generation_advance();
    test_fill_to_full();
    test_random_traffic(900);

    s_axis_tvalid <= 1'b0;
    while (pending_results.size() > 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("%0d items, %0d results checked: %0d creates (%0d full), %0d destroys",
             n_items, n_checked, n_creates, n_full, n_destroys);
    $display("%0d destroys rejected, %0d queries (%0d live), %0d no-ops, %0d wraps",
             n_rejects, n_queries, n_live_hits, n_noops, n_wraps);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// ----- generational_handle_allocator.f -----
+incdir+hw/rtl
hw/rtl/gha_pkg.sv
hw/rtl/gha_ram.sv
hw/rtl/generational_handle_allocator.sv
hw/rtl/gha_checker.sv
dv/tb.sv
